>>> rtl/mrt_pkg.sv
package mrt_pkg;

    localparam int ENTRIES  = 64;
    localparam int KEY_BITS = 64;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ACT_W    = 32;
    localparam int TAG_W    = 128;
    localparam int ROW_W    = KEY_BITS + KEY_BITS + ACT_W + TAG_W;

    localparam logic [ACT_W-1:0] DEFAULT_ACTION_RESET = 32'hFFFF_FFFF;

    localparam logic [1:0] MODE_MATCH  = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_MODIFY = 2'd2;
    localparam logic [1:0] MODE_DELETE = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_MISS    = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_PRESENT = 3'd3;
    localparam logic [2:0] ST_BADIDX  = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  entry_index;
        logic [63:0] key_value;
        logic [63:0] mask_value;
        logic [31:0] action_value;
        logic [63:0] tag_high;
        logic [63:0] tag_low;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  result_index;
        logic [31:0] result_action;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic             load;      // capture input item
        logic             scan_rst;  // clear scan index
        logic             scan_step; // advance scan index
        logic             eval;      // evaluate row read for current index
        logic             wr_free;   // store rule at free slot
        logic             wr_idx;    // store rule at item index
        logic             del_idx;   // clear valid of item index
        logic             finish;    // form result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       mode_scan; // match or add
        logic       scan_last; // current index is final entry
        logic       hit;       // early stop found
        logic       idx_ok;    // item index in range
        logic       is_modify;
        logic       is_add;
        logic       have_free;
    } t_sts;

endpackage

>>> rtl/mrt_ram.sv
module mrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/mrt_datapath.sv
module mrt_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mrt_pkg::t_cmd        i_cmd,
    input  mrt_pkg::t_in_item    i_item,
    input  logic [31:0]          i_default_action,
    output mrt_pkg::t_sts        o_sts,
    output mrt_pkg::t_out_item   o_result
);
    import mrt_pkg::*;

    t_in_item          r_item;
    logic [ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]  r_scan;
    logic [IDX_W-1:0]  r_eval_idx;
    logic              r_hit;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [ACT_W-1:0]  r_hit_act;
    logic              r_have_free;
    logic [IDX_W-1:0]  r_free_idx;
    t_out_item         r_result;

    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [ROW_W-1:0]  wdata;
    logic [ROW_W-1:0]  rdata;
    logic [KEY_BITS-1:0] row_key, row_mask, item_key;
    logic [ACT_W-1:0]  row_act;
    logic [TAG_W-1:0]  row_tag;
    logic              row_valid;
    logic              row_hit;
    logic              idx_ok;

    assign idx_ok  = ({1'b0, r_item.entry_index} < 9'(ENTRIES));
    assign item_key = r_item.key_value[KEY_BITS-1:0];
    assign {row_key, row_mask, row_act, row_tag} = rdata;
    assign row_valid = r_valid[r_eval_idx];

    // per-row test: masked key compare for match, tag compare for add
    always_comb begin
        if (r_item.mode == MODE_MATCH) begin
            row_hit = row_valid && (((row_key ^ item_key) & row_mask) == '0);
        end else begin
            row_hit = row_valid && (row_tag == {r_item.tag_high, r_item.tag_low});
        end
    end

    // rule write port
    assign we    = i_cmd.wr_free | i_cmd.wr_idx;
    assign waddr = i_cmd.wr_free ? r_free_idx : r_item.entry_index[IDX_W-1:0];
    assign wdata = {item_key, r_item.mask_value[KEY_BITS-1:0], r_item.action_value,
                    r_item.tag_high, r_item.tag_low};

    mrt_ram #(.WIDTH(ROW_W), .DEPTH(ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_scan),
        .o_rdata (rdata)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (we) begin
            r_valid[waddr] <= 1'b1;
        end else if (i_cmd.del_idx) begin
            r_valid[r_item.entry_index[IDX_W-1:0]] <= 1'b0;
        end
    end

    // hold item, advance scan, track first hit and first free slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.scan_rst) begin
            r_scan      <= '0;
            r_hit       <= 1'b0;
            r_have_free <= 1'b0;
            r_hit_idx   <= '0;
            r_free_idx  <= '0;
        end else begin
            if (i_cmd.scan_step) begin
                r_scan <= r_scan + 1'b1;
            end
            r_eval_idx <= r_scan;
            if (i_cmd.eval && !r_hit) begin
                if (row_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_eval_idx;
                    r_hit_act <= row_act;
                end else if (!row_valid && !r_have_free) begin
                    r_have_free <= 1'b1;
                    r_free_idx  <= r_eval_idx;
                end
            end
        end
    end

    // form result
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result.status        <= ST_OK;
            r_result.result_index  <= '0;
            r_result.result_action <= '0;
            case (r_item.mode)
                MODE_MATCH: begin
                    if (r_hit) begin
                        r_result.result_index  <= 8'(r_hit_idx);
                        r_result.result_action <= r_hit_act;
                    end else begin
                        r_result.status        <= ST_MISS;
                        r_result.result_action <= i_default_action;
                    end
                end
                MODE_ADD: begin
                    if (r_hit) begin
                        r_result.status       <= ST_PRESENT;
                        r_result.result_index <= 8'(r_hit_idx);
                    end else if (r_have_free) begin
                        r_result.result_index <= 8'(r_free_idx);
                    end else begin
                        r_result.status <= ST_FULL;
                    end
                end
                default: begin
                    if (idx_ok) begin
                        r_result.result_index <= r_item.entry_index;
                    end else begin
                        r_result.status <= ST_BADIDX;
                    end
                end
            endcase
        end
    end

    assign o_sts.mode_scan = (r_item.mode == MODE_MATCH) || (r_item.mode == MODE_ADD);
    assign o_sts.scan_last = (r_eval_idx == IDX_W'(ENTRIES - 1));
    assign o_sts.hit       = r_hit;
    assign o_sts.idx_ok    = idx_ok;
    assign o_sts.is_modify = (r_item.mode == MODE_MODIFY);
    assign o_sts.is_add    = (r_item.mode == MODE_ADD);
    assign o_sts.have_free = r_have_free;
    assign o_result        = r_result;

    // a write never lands on a slot already valid during add
    a_add_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_free |-> !r_valid[r_free_idx])
        else $error("add writes a valid slot");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.wr_free && i_cmd.wr_idx))
        else $error("two writes in one cycle");
    a_del_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.del_idx || i_cmd.wr_idx) |-> idx_ok)
        else $error("indexed write out of range");
endmodule

>>> rtl/mrt_ctrl.sv
module mrt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  mrt_pkg::t_sts i_sts,
    output mrt_pkg::t_cmd o_cmd
);
    import mrt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PRIME, S_SCAN, S_DRAIN, S_EXEC, S_FIN, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.scan_rst = 1'b1;
                    n_state        = S_PRIME;
                end
            end
            S_PRIME: begin
                // first read address issued; row 0 appears next cycle
                o_cmd.scan_step = 1'b1;
                n_state = i_sts.mode_scan ? S_SCAN : S_EXEC;
            end
            S_SCAN: begin
                // read data valid for r_eval_idx from here on
                o_cmd.eval      = 1'b1;
                o_cmd.scan_step = 1'b1;
                n_state = S_DRAIN;
            end
            S_DRAIN: begin
                o_cmd.eval      = 1'b1;
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last || i_sts.hit) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_sts.mode_scan) begin
                    if (i_sts.idx_ok) begin
                        o_cmd.wr_idx  = i_sts.is_modify;
                        o_cmd.del_idx = !i_sts.is_modify;
                    end
                end else if (!i_sts.hit && i_sts.have_free) begin
                    o_cmd.wr_free = i_sts.is_add;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_out_valid  = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold state and registered valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_valid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_OUT))
        else $error("output valid outside output state");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !o_in_ready)
        else $error("input taken while result pending");
    a_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid)
        else $error("finish without result");
endmodule

>>> rtl/masked_rule_table_first_match_unit.sv
// Match and add: the scan reads one rule row per cycle from the rule RAM and stops at the
// first hit. Modify and delete skip the scan. One item at a time: the next item is accepted
// only after the output handshake and the return to idle.
// Reset (synchronous, active low) clears all valid bits at once and sets the default
// action to all ones; rule storage is left undefined.
module masked_rule_table_first_match_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mrt_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mrt_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata
);
    import mrt_pkg::*;

    t_cmd        cmd;
    t_sts        sts;
    logic [31:0] r_default_action;

    // default action register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_action <= DEFAULT_ACTION_RESET;
        end else if (i_cfg_we) begin
            r_default_action <= i_cfg_wdata;
        end
    end

    mrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mrt_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_item           (i_in_item),
        .i_default_action (r_default_action),
        .o_sts            (sts),
        .o_result         (o_out_item)
    );
endmodule
